FILE: src/assert_macros.svh
// Assertion macros shared by the odometry RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, disabled while rst is high.
`define ODO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge of clk, including the reset cycles.
`define ODO_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/odo_pkg.sv
// Shared constants, types and tables of the odometry block.
// Depends on nothing; used by odo_cordic and the top level.
package odo_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int POS_FRAC_BITS = 16;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_IDX_W   = $clog2(CORDIC_STEPS);
  // Sine and cosine in Q1.30 with one guard bit for growth and negation.
  localparam int TRIG_W       = 33;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INIT = 33'sd652032874;

  localparam logic signed [TRIG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861
  };

  // Configuration register indexes.
  localparam logic REG_METRES_PER_COUNT = 1'b0;
  localparam logic REG_TURN_PER_COUNT   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } odo_cord_stat_t;

endpackage

FILE: src/differential_drive_odometry_core.sv
// Differential-drive odometry core. Each input beat carries the right and left
// encoder counts of one tick; the block adds (right - left) * turn_per_count to
// the heading, forms distance = (right + left) * metres_per_count, and adds
// distance * sin(heading) to x and distance * cos(heading) to y, saturating the
// Q15.16 position at the int32 limits. One output beat per tick gives x and y in
// decimetres (truncated toward zero, saturated to int16) and the heading. Each tick
// runs through two multiply steps for the heading and the distance, the 16 steps of
// the iterative CORDIC, a wait state that collects its result, four multiply and
// accumulate steps for x and y on one shared 26 x 33 multiplier and one shared
// accumulator, and a step that loads the output register, which presents the beat.
// The next input beat can be taken once the result has moved to the output register,
// even while the output beat still waits; a stalled result that is still waiting
// when the next tick finishes holds that tick back. Depends on odo_pkg, odo_cordic
// and assert_macros.svh.
`include "assert_macros.svh"

module differential_drive_odometry_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] right_count, [15:8] left_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [15:0] x_decimetres, [31:16] y_decimetres,
                                 // [47:32] heading_angle
);
  import odo_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TURN = 4'd1;
  localparam logic [3:0] S_DIST = 4'd2;
  localparam logic [3:0] S_CORD = 4'd3;
  localparam logic [3:0] S_MULX = 4'd4;
  localparam logic [3:0] S_ACCX = 4'd5;
  localparam logic [3:0] S_MULY = 4'd6;
  localparam logic [3:0] S_ACCY = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam int MUL_A_W    = 26;
  localparam int DIST_W     = 25;
  localparam int PROD_W     = MUL_A_W + TRIG_W;
  localparam int STEP_SHIFT = 46 - POS_FRAC_BITS;
  localparam int STEPV_W    = PROD_W - STEP_SHIFT;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (STEP_SHIFT - 1);

  logic [3:0]                   state;
  logic [15:0]                  metres_per_count, turn_per_count;
  logic [ANGLE_BITS-1:0]        heading;
  logic signed [31:0]           pos_x, pos_y;
  logic signed [7:0]            right_r, left_r;
  logic signed [DIST_W-1:0]     travel;
  logic signed [PROD_W-1:0]     prod;

  logic signed [MUL_A_W-1:0]    mul_a;
  logic signed [TRIG_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]     mul_p;
  logic signed [PROD_W-1:0]     round_sum;
  logic signed [STEPV_W-1:0]    step;
  logic signed [31:0]           pos_sel;
  logic signed [33:0]           pos_sum;
  logic signed [31:0]           pos_next;

  logic                         cord_start;
  odo_cord_stat_t               cord_stat;
  logic signed [TRIG_W-1:0]     sin_val, cos_val;
  logic [ANGLE_BITS+15:0]       head_wide;

  function automatic logic [15:0] to_decimetres(input logic signed [31:0] p);
    logic signed [35:0] t;
    logic signed [35:0] q;
    logic [15:0]        d;
    t = (36'(p) <<< 3) + (36'(p) <<< 1);
    // Truncate toward zero: bias a negative value before the floor shift.
    if (t < 0) t = t + 36'((64'(1) << POS_FRAC_BITS) - 1);
    q = t >>> POS_FRAC_BITS;
    if (q > 36'sd32767) d = 16'h7FFF;
    else if (q < -36'sd32768) d = 16'h8000;
    else d = q[15:0];
    return d;
  endfunction

  odo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .angle   (heading),
    .stat    (cord_stat),
    .sin_val (sin_val),
    .cos_val (cos_val)
  );

  assign s_tready   = (state == S_IDLE) && !rst;
  assign cord_start = (state == S_DIST);

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      S_TURN: begin
        mul_a = MUL_A_W'(9'(right_r) - 9'(left_r));
        mul_b = $signed({{(TRIG_W-16){1'b0}}, turn_per_count});
      end
      S_DIST: begin
        mul_a = MUL_A_W'(9'(right_r) + 9'(left_r));
        mul_b = $signed({{(TRIG_W-16){1'b0}}, metres_per_count});
      end
      S_MULY: begin
        mul_a = MUL_A_W'(travel);
        mul_b = cos_val;
      end
      default: begin
        mul_a = MUL_A_W'(travel);
        mul_b = sin_val;
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Shared rounding accumulator; ties round toward plus infinity.
  always_comb begin
    round_sum = prod + ROUND_HALF;
    step      = STEPV_W'(round_sum >>> STEP_SHIFT);
    pos_sel   = (state == S_ACCY) ? pos_y : pos_x;
    pos_sum   = 34'(pos_sel) + 34'(step);
    if (pos_sum > 34'sd2147483647) pos_next = 32'sh7FFF_FFFF;
    else if (pos_sum < -34'sd2147483648) pos_next = 32'sh8000_0000;
    else pos_next = pos_sum[31:0];
  end

  assign head_wide = (ANGLE_BITS + 16)'(heading) << 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      m_tvalid         <= 1'b0;
      metres_per_count <= '0;
      turn_per_count   <= '0;
      heading          <= '0;
      pos_x            <= '0;
      pos_y            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_METRES_PER_COUNT: metres_per_count <= cfg_data;
          REG_TURN_PER_COUNT:   turn_per_count   <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            right_r <= s_tdata[7:0];
            left_r  <= s_tdata[15:8];
            state   <= S_TURN;
          end
        end
        S_TURN: begin
          heading <= heading + mul_p[ANGLE_BITS-1:0];
          state   <= S_DIST;
        end
        S_DIST: begin
          travel <= mul_p[DIST_W-1:0];
          state  <= S_CORD;
        end
        S_CORD: begin
          if (cord_stat.done) state <= S_MULX;
        end
        S_MULX: begin
          prod  <= mul_p;
          state <= S_ACCX;
        end
        S_ACCX: begin
          pos_x <= pos_next;
          state <= S_MULY;
        end
        S_MULY: begin
          prod  <= mul_p;
          state <= S_ACCY;
        end
        S_ACCY: begin
          pos_y <= pos_next;
          state <= S_OUT;
        end
        S_OUT: begin
          // Wait until the output register is free before loading the beat.
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {head_wide[ANGLE_BITS+15:ANGLE_BITS],
                         to_decimetres(pos_y), to_decimetres(pos_x)};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ODO_ASSERT(a_cord_start_idle, cord_start |-> !cord_stat.busy, "CORDIC restarted while busy")
  `ODO_ASSERT(a_cord_done_state, cord_stat.done |-> (state == S_CORD), "CORDIC done out of step")
  `ODO_ASSERT(a_out_wait, (state == S_OUT && m_tvalid && !m_tready) |=> state == S_OUT, "beat lost")
  `ODO_ASSERT(a_heading_hold, (state != S_TURN) |=> $stable(heading), "heading changed out of step")

endmodule

FILE: src/odo_cordic.sv
// Iterative rotation-mode CORDIC: one add/subtract step per cycle.
// Depends on odo_pkg for the arctangent table, widths and status type.
module odo_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [odo_pkg::ANGLE_BITS-1:0]      angle,
  output odo_pkg::odo_cord_stat_t             stat,
  output logic signed [odo_pkg::TRIG_W-1:0]   sin_val,
  output logic signed [odo_pkg::TRIG_W-1:0]   cos_val
);
  import odo_pkg::*;

  logic signed [TRIG_W-1:0] x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] dx, dy;
  logic [STEP_IDX_W-1:0]    cnt;
  logic [1:0]               quad;
  logic                     busy, fin;
  logic [31:0]              a32;
  logic [31:0]              a_round;
  logic [1:0]               quad_in;
  logic [31:0]              resid;

  // The nearest quarter turn is taken out; the residual lies in [-1/8, 1/8) turn.
  always_comb begin
    a32     = 32'(angle) << (32 - ANGLE_BITS);
    a_round = a32 + 32'h2000_0000;
    quad_in = a_round[31:30];
    resid   = a32 - {quad_in, 30'b0};
  end

  assign dx = y_r >>> cnt;
  assign dy = x_r >>> cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        fin  <= 1'b0;
        cnt  <= '0;
        quad <= quad_in;
        x_r  <= CORDIC_GAIN_INIT;
        y_r  <= '0;
        z_r  <= TRIG_W'($signed(resid));
      end else if (busy) begin
        if (!z_r[TRIG_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - ATAN_TAB[cnt];
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + ATAN_TAB[cnt];
        end
        cnt <= cnt + 1'b1;
        fin <= (cnt == STEP_IDX_W'(CORDIC_STEPS - 1));
        if (cnt == STEP_IDX_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        fin <= 1'b0;
      end
    end
  end

  // Put the quarter turn back.
  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = x_r;
        sin_val = y_r;
      end
      2'd1: begin
        cos_val = -y_r;
        sin_val = x_r;
      end
      2'd2: begin
        cos_val = -x_r;
        sin_val = -y_r;
      end
      default: begin
        cos_val = y_r;
        sin_val = -x_r;
      end
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = fin;

endmodule
